[rtl/core/cau_pkg.sv]
// ----------------------------------------------------------------------------
// Complex arithmetic unit package
// Operation and status codes, and the control word that travels down the
// pipeline beside the data.
// ----------------------------------------------------------------------------
package cau_pkg;

  localparam int RES_W = 64;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_CMP = 3'd4;

  localparam logic [2:0] ST_OK   = 3'd0;
  localparam logic [2:0] ST_REAL = 3'd1;
  localparam logic [2:0] ST_IMAG = 3'd2;
  localparam logic [2:0] ST_DIV0 = 3'd3;
  localparam logic [2:0] ST_SAT  = 3'd4;

  typedef struct packed {
    logic       valid;
    logic       is_div;
    logic       zero_res;
    logic       eq;
    logic [2:0] status;
  } cau_ctrl_t;

endpackage

[rtl/core/complex_arithmetic_unit_top.sv]
// ----------------------------------------------------------------------------
// Complex arithmetic unit
// Add, subtract, multiply, divide and compare of two fixed-point complex
// operands, fully pipelined.
// ----------------------------------------------------------------------------
// The unit takes one request in every clock cycle and busy is always low. Every
// operation takes the same path: done pulses for one cycle once the request has
// passed the input register, the front end, the divider steps and the sign
// restore and clamp stages, with results in request order. The divider is
// a chain of OPERAND_WIDTH + FRAC_BITS restoring steps with one step per stage;
// the receiver must take each result in the cycle that done is high.
module complex_arithmetic_unit_top #(
  parameter int FRAC_BITS     = 8,
  parameter int OPERAND_WIDTH = 32,
  parameter int PART_LIMIT    = 1000000
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [2:0]                        operation,
  input  logic signed [OPERAND_WIDTH-1:0]   first_real,
  input  logic signed [OPERAND_WIDTH-1:0]   first_imag,
  input  logic signed [OPERAND_WIDTH-1:0]   second_real,
  input  logic signed [OPERAND_WIDTH-1:0]   second_imag,
  output logic                              done,
  output logic signed [cau_pkg::RES_W-1:0]  result_real,
  output logic signed [cau_pkg::RES_W-1:0]  result_imag,
  output logic                              is_equal,
  output logic [2:0]                        status
);
  import cau_pkg::*;

  localparam int OW  = OPERAND_WIDTH;
  localparam int SW  = 2 * OW + 1;
  localparam int DW  = 2 * OW;
  localparam int QB  = OW + FRAC_BITS;
  localparam int SBW = 2 * SW + 2;
  localparam int EW  = (SW > RES_W) ? SW : RES_W + 1;
  localparam int LAT = QB + 6;
  localparam logic signed [RES_W-1:0] MAX_OUT = {1'b0, {(RES_W-1){1'b1}}};
  localparam logic signed [RES_W-1:0] MIN_OUT = {1'b1, {(RES_W-1){1'b0}}};

  // Input register
  logic                 v0;
  logic [2:0]           op0;
  logic signed [OW-1:0] a0, b0, c0, d0;

  // Pipeline taps: index 0 is the front end output, QB the last divider step.
  cau_ctrl_t            ctrl_s   [QB+1];
  logic [SBW-1:0]       side_s   [QB+1];
  logic [DW-1:0]        den_s    [QB+1];
  logic [DW-1:0]        rem_re_s [QB+1];
  logic [DW-1:0]        rem_im_s [QB+1];
  logic [QB-1:0]        nq_re_s  [QB+1];
  logic [QB-1:0]        nq_im_s  [QB+1];

  logic signed [SW-1:0] val_re0, val_im0;
  logic                 sign_re0, sign_im0;

  // Sign restore stage
  cau_ctrl_t            ctrl_f;
  logic signed [EW-1:0] val_re_f, val_im_f;
  logic signed [EW-1:0] q_re, q_im;
  logic signed [SW-1:0] val_re_l, val_im_l;
  logic                 sign_re_l, sign_im_l;

  // Clamp stage
  logic                 sat_re, sat_im;
  logic signed [RES_W-1:0] cl_re, cl_im;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= start && !busy;
    end
    op0 <= operation;
    a0  <= first_real;
    b0  <= first_imag;
    c0  <= second_real;
    d0  <= second_imag;
  end

  cau_prod #(
    .FRAC_BITS    (FRAC_BITS),
    .OPERAND_WIDTH(OPERAND_WIDTH),
    .PART_LIMIT   (PART_LIMIT)
  ) u_prod (
    .clk      (clk),
    .rst      (rst),
    .in_valid (v0),
    .op       (op0),
    .a        (a0),
    .b        (b0),
    .c        (c0),
    .d        (d0),
    .ctrl_o   (ctrl_s[0]),
    .val_re_o (val_re0),
    .val_im_o (val_im0),
    .sign_re_o(sign_re0),
    .sign_im_o(sign_im0),
    .den_o    (den_s[0]),
    .rem_re_o (rem_re_s[0]),
    .rem_im_o (rem_im_s[0]),
    .nq_re_o  (nq_re_s[0]),
    .nq_im_o  (nq_im_s[0])
  );

  assign side_s[0] = {sign_re0, sign_im0, val_re0, val_im0};

  for (genvar g = 0; g < QB; g++) begin : g_div
    cau_div_stage #(
      .DW (DW),
      .QB (QB),
      .SBW(SBW)
    ) u_stage (
      .clk     (clk),
      .rst     (rst),
      .ctrl_i  (ctrl_s[g]),
      .side_i  (side_s[g]),
      .den_i   (den_s[g]),
      .rem_re_i(rem_re_s[g]),
      .rem_im_i(rem_im_s[g]),
      .nq_re_i (nq_re_s[g]),
      .nq_im_i (nq_im_s[g]),
      .ctrl_o  (ctrl_s[g+1]),
      .side_o  (side_s[g+1]),
      .den_o   (den_s[g+1]),
      .rem_re_o(rem_re_s[g+1]),
      .rem_im_o(rem_im_s[g+1]),
      .nq_re_o (nq_re_s[g+1]),
      .nq_im_o (nq_im_s[g+1])
    );
  end

  always_comb begin
    sign_re_l = side_s[QB][SBW-1];
    sign_im_l = side_s[QB][SBW-2];
    val_re_l  = $signed(side_s[QB][2*SW-1:SW]);
    val_im_l  = $signed(side_s[QB][SW-1:0]);
    q_re      = EW'($signed({1'b0, nq_re_s[QB]}));
    q_im      = EW'($signed({1'b0, nq_im_s[QB]}));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_f.valid <= 1'b0;
    end else begin
      ctrl_f.valid <= ctrl_s[QB].valid;
    end
    ctrl_f.is_div   <= ctrl_s[QB].is_div;
    ctrl_f.zero_res <= ctrl_s[QB].zero_res;
    ctrl_f.eq       <= ctrl_s[QB].eq;
    ctrl_f.status   <= ctrl_s[QB].status;
    if (ctrl_s[QB].zero_res) begin
      val_re_f <= '0;
      val_im_f <= '0;
    end else if (ctrl_s[QB].is_div) begin
      val_re_f <= sign_re_l ? -q_re : q_re;
      val_im_f <= sign_im_l ? -q_im : q_im;
    end else begin
      val_re_f <= EW'(val_re_l);
      val_im_f <= EW'(val_im_l);
    end
  end

  // A part fits the output when every bit above the output sign bit matches it.
  always_comb begin
    sat_re = (val_re_f[EW-1:RES_W-1] != '0) && (val_re_f[EW-1:RES_W-1] != '1);
    sat_im = (val_im_f[EW-1:RES_W-1] != '0) && (val_im_f[EW-1:RES_W-1] != '1);
    cl_re  = sat_re ? (val_re_f[EW-1] ? MIN_OUT : MAX_OUT) : val_re_f[RES_W-1:0];
    cl_im  = sat_im ? (val_im_f[EW-1] ? MIN_OUT : MAX_OUT) : val_im_f[RES_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctrl_f.valid;
    end
    result_real <= cl_re;
    result_imag <= cl_im;
    is_equal    <= ctrl_f.eq;
    if (ctrl_f.zero_res) begin
      status <= ctrl_f.status;
    end else begin
      status <= (sat_re || sat_im) ? ST_SAT : ST_OK;
    end
  end

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LAT))
    else $error("result without a request at the pipeline latency");

  a_div0_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_DIV0) |-> (result_real == '0 && result_imag == '0))
    else $error("divide by zero with a nonzero result");

  a_equal_clean: assert property (@(posedge clk) disable iff (rst)
    (done && is_equal) |-> (status == ST_OK && result_real == '0 && result_imag == '0))
    else $error("equal flag with a result or an error");
`endif

endmodule

[rtl/core/cau_prod.sv]
// ----------------------------------------------------------------------------
// Complex arithmetic front end
// Limit checks, partial products, sums, and preparation of the divider
// operands, over three register stages.
// ----------------------------------------------------------------------------
module cau_prod #(
  parameter int FRAC_BITS     = 8,
  parameter int OPERAND_WIDTH = 32,
  parameter int PART_LIMIT    = 1000000
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       in_valid,
  input  logic [2:0]                                 op,
  input  logic signed [OPERAND_WIDTH-1:0]            a,
  input  logic signed [OPERAND_WIDTH-1:0]            b,
  input  logic signed [OPERAND_WIDTH-1:0]            c,
  input  logic signed [OPERAND_WIDTH-1:0]            d,
  output cau_pkg::cau_ctrl_t                         ctrl_o,
  output logic signed [2*OPERAND_WIDTH:0]            val_re_o,
  output logic signed [2*OPERAND_WIDTH:0]            val_im_o,
  output logic                                       sign_re_o,
  output logic                                       sign_im_o,
  output logic [2*OPERAND_WIDTH-1:0]                 den_o,
  output logic [2*OPERAND_WIDTH-1:0]                 rem_re_o,
  output logic [2*OPERAND_WIDTH-1:0]                 rem_im_o,
  output logic [OPERAND_WIDTH+FRAC_BITS-1:0]         nq_re_o,
  output logic [OPERAND_WIDTH+FRAC_BITS-1:0]         nq_im_o
);
  import cau_pkg::*;

  localparam int OW = OPERAND_WIDTH;
  localparam int SW = 2 * OW + 1;
  localparam int DW = 2 * OW;
  localparam int QB = OW + FRAC_BITS;
  localparam int NW = SW + FRAC_BITS;
  localparam logic signed [63:0] LIM_RAW = 64'(PART_LIMIT) <<< FRAC_BITS;
  localparam logic signed [SW-1:0] BIAS = SW'((SW'(1) << FRAC_BITS) - 1);

  // Stage 1
  logic                  v1, eq1, dz1;
  logic [2:0]            op1, st1;
  logic signed [DW-1:0]  p_ac, p_bd, p_ad, p_bc, p_cc, p_dd;
  logic signed [OW:0]    s_re1, s_im1;
  logic [2:0]            st_next;

  // Stage 2
  logic                  v2, eq2, dz2;
  logic [2:0]            op2, st2;
  logic signed [SW-1:0]  val_re2, val_im2;
  logic [DW-1:0]         den2;
  logic signed [SW-1:0]  mre, mim, nre, nim;

  // Stage 3 inputs
  logic                  is_div2, err2;
  logic signed [SW-1:0]  sc_re, sc_im;
  logic [SW-1:0]         abs_re, abs_im;
  logic [NW-1:0]         n_re, n_im;

  always_comb begin
    if (64'(a) > LIM_RAW) begin
      st_next = ST_REAL;
    end else if (64'(b) > LIM_RAW) begin
      st_next = ST_IMAG;
    end else if (64'(c) > LIM_RAW) begin
      st_next = ST_REAL;
    end else if (64'(d) > LIM_RAW) begin
      st_next = ST_IMAG;
    end else begin
      st_next = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= in_valid;
    end
    op1   <= op;
    st1   <= st_next;
    eq1   <= (a == c) && (b == d);
    dz1   <= (c == '0) && (d == '0);
    p_ac  <= a * c;
    p_bd  <= b * d;
    p_ad  <= a * d;
    p_bc  <= b * c;
    p_cc  <= c * c;
    p_dd  <= d * d;
    s_re1 <= (op == OP_SUB) ? ((OW+1)'(a) - (OW+1)'(c)) : ((OW+1)'(a) + (OW+1)'(c));
    s_im1 <= (op == OP_SUB) ? ((OW+1)'(b) - (OW+1)'(d)) : ((OW+1)'(b) + (OW+1)'(d));
  end

  always_comb begin
    mre = SW'(p_ac) - SW'(p_bd);
    mim = SW'(p_ad) + SW'(p_bc);
    nre = SW'(p_ac) + SW'(p_bd);
    nim = SW'(p_bc) - SW'(p_ad);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    op2  <= op1;
    st2  <= st1;
    eq2  <= eq1;
    dz2  <= dz1;
    den2 <= DW'(unsigned'(p_cc)) + DW'(unsigned'(p_dd));
    if (op1 inside {OP_ADD, OP_SUB}) begin
      val_re2 <= SW'(s_re1);
      val_im2 <= SW'(s_im1);
    end else if (op1 == OP_DIV) begin
      val_re2 <= nre;
      val_im2 <= nim;
    end else begin
      val_re2 <= mre;
      val_im2 <= mim;
    end
  end

  // Products are scaled back with truncation toward zero: a negative value
  // gets a bias of all ones below the binary point before the shift.
  always_comb begin
    is_div2 = (op2 == OP_DIV);
    err2    = (st2 != ST_OK);
    sc_re   = $signed(val_re2 + (val_re2[SW-1] ? BIAS : '0)) >>> FRAC_BITS;
    sc_im   = $signed(val_im2 + (val_im2[SW-1] ? BIAS : '0)) >>> FRAC_BITS;
    abs_re  = val_re2[SW-1] ? SW'(-val_re2) : SW'(val_re2);
    abs_im  = val_im2[SW-1] ? SW'(-val_im2) : SW'(val_im2);
    n_re    = NW'(abs_re) << FRAC_BITS;
    n_im    = NW'(abs_im) << FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_o.valid <= 1'b0;
    end else begin
      ctrl_o.valid <= v2;
    end
    ctrl_o.is_div   <= is_div2;
    ctrl_o.zero_res <= err2 || !(op2 inside {OP_ADD, OP_SUB, OP_MUL, OP_DIV}) ||
                       (is_div2 && dz2);
    ctrl_o.eq       <= !err2 && (op2 == OP_CMP) && eq2;
    ctrl_o.status   <= err2 ? st2 : ((is_div2 && dz2) ? ST_DIV0 : ST_OK);
    val_re_o  <= (op2 == OP_MUL) ? sc_re : val_re2;
    val_im_o  <= (op2 == OP_MUL) ? sc_im : val_im2;
    sign_re_o <= val_re2[SW-1];
    sign_im_o <= val_im2[SW-1];
    den_o     <= den2;
    // The quotient is assumed to fit in QB bits, which is not checked, so the top
    // of the numerator seeds the remainder and only QB steps remain.
    rem_re_o  <= DW'(n_re >> QB);
    rem_im_o  <= DW'(n_im >> QB);
    nq_re_o   <= n_re[QB-1:0];
    nq_im_o   <= n_im[QB-1:0];
  end

endmodule

[rtl/core/cau_div_stage.sv]
// ----------------------------------------------------------------------------
// Complex arithmetic divider stage
// One restoring division step for the real and imaginary numerators over a
// shared denominator, with the item's other fields carried alongside.
// ----------------------------------------------------------------------------
module cau_div_stage #(
  parameter int DW  = 64,
  parameter int QB  = 40,
  parameter int SBW = 132
) (
  input  logic               clk,
  input  logic               rst,
  input  cau_pkg::cau_ctrl_t ctrl_i,
  input  logic [SBW-1:0]     side_i,
  input  logic [DW-1:0]      den_i,
  input  logic [DW-1:0]      rem_re_i,
  input  logic [DW-1:0]      rem_im_i,
  input  logic [QB-1:0]      nq_re_i,
  input  logic [QB-1:0]      nq_im_i,
  output cau_pkg::cau_ctrl_t ctrl_o,
  output logic [SBW-1:0]     side_o,
  output logic [DW-1:0]      den_o,
  output logic [DW-1:0]      rem_re_o,
  output logic [DW-1:0]      rem_im_o,
  output logic [QB-1:0]      nq_re_o,
  output logic [QB-1:0]      nq_im_o
);
  import cau_pkg::*;

  // The low part of nq holds quotient bits, the high part the numerator bits
  // still to be brought down.
  function automatic logic [DW+QB-1:0] div_step(input logic [DW-1:0] rem,
                                                input logic [QB-1:0] nq,
                                                input logic [DW-1:0] den);
    logic [DW:0] t;
    logic        ge;
    logic [DW:0] diff;
    t    = {rem, nq[QB-1]};
    ge   = (t >= {1'b0, den});
    diff = t - {1'b0, den};
    return {(ge ? diff[DW-1:0] : t[DW-1:0]), nq[QB-2:0], ge};
  endfunction

  logic [DW+QB-1:0] st_re, st_im;

  assign st_re = div_step(rem_re_i, nq_re_i, den_i);
  assign st_im = div_step(rem_im_i, nq_im_i, den_i);

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_o.valid <= 1'b0;
    end else begin
      ctrl_o.valid <= ctrl_i.valid;
    end
    ctrl_o.is_div   <= ctrl_i.is_div;
    ctrl_o.zero_res <= ctrl_i.zero_res;
    ctrl_o.eq       <= ctrl_i.eq;
    ctrl_o.status   <= ctrl_i.status;
    side_o   <= side_i;
    den_o    <= den_i;
    rem_re_o <= st_re[DW+QB-1:QB];
    nq_re_o  <= st_re[QB-1:0];
    rem_im_o <= st_im[DW+QB-1:QB];
    nq_im_o  <= st_im[QB-1:0];
  end

endmodule
